FILE: hdl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/pfc_pkg.sv
// Package for the packet framer: constants, result type and CRC byte functions.
// Depends on nothing; used by the core and the testbench.
package pfc_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int SIZE_LIMIT  = (MAX_PAYLOAD < 122) ? MAX_PAYLOAD : 122;
    localparam int CRC8_MAX_SIZE = 15;
    localparam int HEADER_LEN  = 3;

    localparam logic [7:0]  CRC8_POLY  = 8'h31;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_SIZE_ERR = 2'd2;

    localparam logic CMD_TX = 1'b0;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic [1:0] status;
        logic       last;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/pfc_if.sv
// Valid/ready channel interfaces of the packet framer: byte input and result output.
// Depends on nothing.
interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface pfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output frame_end, output status,
                    output last, input ready);
    modport sink (input valid, input out_byte, input frame_end, input status,
                  input last, output ready);
endinterface

FILE: hdl/packet_framer_crc8_crc16_core.sv
// Packet framer and checker with CRC-8 / CRC-16 CCITT, byte serial.
// Depends on pfc_pkg, pfc_if.sv and assert_macros.svh.
//
// Usage: bytes enter on i_in (command, data_byte); results leave on o_out.
// A frame is address, size, type, payload and a check value. The first byte
// of a frame selects transmit (command 0) or receive (command 1).
// In transmit every byte is echoed and the CRC bytes follow the last payload
// byte; in receive every byte is echoed and the final check byte carries
// frame_end with the status. The last flag marks the final result of a byte.
// Each accepted byte is processed in the cycle of its transfer and its one to
// three results are written into a four-entry result queue; o_out shows the
// registered result at the head of the queue.
// Throughput is one byte per cycle while each byte yields one result and o_out
// is not stalled; a byte that yields two or three results holds i_in.ready low
// until the queue drains to one entry, so the ready threshold sets this figure.
// Synchronous reset empties the queue and returns to the start of a frame.
// When the receiver stalls, results stay in the queue and i_in.ready falls
// once more than one result is waiting.
`include "assert_macros.svh"

module packet_framer_crc8_crc16_core
    import pfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfc_in_if.sink       i_in,
    pfc_out_if.source    o_out
);

    logic [6:0]  r_pos, n_pos;
    logic [6:0]  r_size, n_size;
    logic        r_dir, n_dir;
    logic [7:0]  r_crc8, n_crc8;
    logic [15:0] r_crc16, n_crc16;
    logic [7:0]  r_rx_lo, n_rx_lo;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    t_result     w_res [MAX_RES];
    logic [1:0]  w_num;
    logic        w_accept;
    logic        w_pop;
    logic        w_end;
    logic [7:0]  w_b;
    logic [7:0]  w_c8;
    logic [15:0] w_c16;
    logic [6:0]  w_end_pos;
    logic [6:0]  w_pos_inc;
    t_result     w_head;

    assign w_b       = i_in.data_byte;
    assign w_c8      = crc8_byte(r_crc8, w_b);
    assign w_c16     = crc16_byte(r_crc16, w_b);
    assign w_end_pos = 7'(HEADER_LEN) + r_size;
    assign w_pos_inc = r_pos + 7'd1;

    assign i_in.ready = (r_count <= CNT_W'(1));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pop      = o_out.valid && o_out.ready;

    always_comb begin
        n_pos   = r_pos;
        n_size  = r_size;
        n_dir   = r_dir;
        n_crc8  = r_crc8;
        n_crc16 = r_crc16;
        n_rx_lo = r_rx_lo;
        w_end   = 1'b0;
        w_num   = 2'd1;
        for (int k = 0; k < MAX_RES; k++) begin
            w_res[k] = '0;
        end
        w_res[0].out_byte = w_b;
        w_res[0].status   = ST_OK;

        if (r_pos == 7'd0) begin
            n_dir   = i_in.command;
            n_crc8  = w_c8;
            n_crc16 = w_c16;
            n_pos   = 7'd1;
        end else if (r_pos == 7'd1) begin
            if (w_b > 8'(SIZE_LIMIT)) begin
                w_res[0].frame_end = 1'b1;
                w_res[0].status    = ST_SIZE_ERR;
                w_end = 1'b1;
            end else begin
                n_size  = w_b[6:0];
                n_crc8  = w_c8;
                n_crc16 = w_c16;
                n_pos   = 7'd2;
            end
        end else if (r_pos < w_end_pos) begin
            n_crc8  = w_c8;
            n_crc16 = w_c16;
            n_pos   = w_pos_inc;
            if (w_pos_inc == w_end_pos && r_dir == CMD_TX) begin
                w_end = 1'b1;
                if (r_size <= 7'(CRC8_MAX_SIZE)) begin
                    w_num = 2'd2;
                    w_res[1].out_byte  = w_c8;
                    w_res[1].frame_end = 1'b1;
                end else begin
                    w_num = 2'd3;
                    w_res[1].out_byte  = w_c16[7:0];
                    w_res[2].out_byte  = w_c16[15:8];
                    w_res[2].frame_end = 1'b1;
                end
            end
        end else begin
            if (r_size <= 7'(CRC8_MAX_SIZE)) begin
                w_res[0].frame_end = 1'b1;
                w_res[0].status    = (r_crc8 != w_b) ? ST_CRC_ERR : ST_OK;
                w_end = 1'b1;
            end else if (r_pos == w_end_pos) begin
                n_rx_lo = w_b;
                n_pos   = w_pos_inc;
            end else begin
                w_res[0].frame_end = 1'b1;
                w_res[0].status    = (r_crc16 != {w_b, r_rx_lo}) ? ST_CRC_ERR : ST_OK;
                w_end = 1'b1;
            end
        end

        case (w_num)
            2'd3:    w_res[2].last = 1'b1;
            2'd2:    w_res[1].last = 1'b1;
            default: w_res[0].last = 1'b1;
        endcase

        if (w_end) begin
            n_pos   = '0;
            n_size  = '0;
            n_dir   = CMD_TX;
            n_crc8  = CRC8_INIT;
            n_crc16 = CRC16_INIT;
            n_rx_lo = '0;
        end

        n_count = r_count + (w_accept ? CNT_W'(w_num) : CNT_W'(0))
                - (w_pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_size  <= '0;
            r_dir   <= CMD_TX;
            r_crc8  <= CRC8_INIT;
            r_crc16 <= CRC16_INIT;
            r_rx_lo <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_pos   <= n_pos;
                r_size  <= n_size;
                r_dir   <= n_dir;
                r_crc8  <= n_crc8;
                r_crc16 <= n_crc16;
                r_rx_lo <= n_rx_lo;
                r_wr    <= r_wr + PTR_W'(w_num);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (k < int'(w_num)) begin
                    r_mem[r_wr + PTR_W'(k)] <= w_res[k];
                end
            end
        end
    end

    assign w_head          = r_mem[r_rd];
    assign o_out.valid     = (r_count != '0);
    assign o_out.out_byte  = w_head.out_byte;
    assign o_out.frame_end = w_head.frame_end;
    assign o_out.status    = w_head.status;
    assign o_out.last      = w_head.last;

    `ASSERT_CLK(a_count_bound, (r_count <= CNT_W'(FIFO_DEPTH)), "result queue overflow")
    `ASSERT_CLK(a_end_clears, (w_accept && w_end |=> r_pos == 7'd0 && r_size == 7'd0),
        "frame state not cleared after frame end")
    `ASSERT_CLK(a_pos_bound, ({1'b0, r_pos} <= {1'b0, r_size} + 8'(HEADER_LEN + 1)),
        "byte position ran past the check bytes")
    `ASSERT_CLK(a_status_on_end, (o_out.valid && !o_out.frame_end |-> o_out.status == ST_OK),
        "status set on a result without frame end")

endmodule

FILE: verif/testbench.sv
// Testbench for packet_framer_crc8_crc16_core: drives transmit, receive, oversize and
// noise byte streams and checks every result against a CRC frame predictor.
// Depends on pfc_pkg, the pfc_in_if/pfc_out_if interfaces and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import pfc_pkg::*;

    localparam logic CMD_RX = ~CMD_TX;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   bytes_sent;

    pfc_in_if  in_ch ();
    pfc_out_if out_ch ();

    packet_framer_crc8_crc16_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    function automatic logic [7:0] next_crc8(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC8_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] next_crc16(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC16_POLY;
            end
        end
        return c;
    endfunction

    class frame_tracker;
        t_result     awaited[$];
        logic [6:0]  pos;
        logic [6:0]  frame_len;
        logic        dir;
        logic [7:0]  crc8;
        logic [15:0] crc16;
        logic [7:0]  check_low;
        int          mismatches;
        int          results_seen;
        int          frames_ok;
        int          frames_crc_bad;
        int          frames_too_long;

        function new();
            restart();
        endfunction

        function void restart();
            pos       = '0;
            frame_len = '0;
            dir       = CMD_TX;
            crc8      = CRC8_INIT;
            crc16     = CRC16_INIT;
            check_low = '0;
        endfunction

        function void absorb(logic [7:0] b);
            crc8  = next_crc8(crc8, b);
            crc16 = next_crc16(crc16, b);
        endfunction

        function void add(logic [7:0] b, logic fin, logic [1:0] st);
            t_result r;
            r.out_byte  = b;
            r.frame_end = fin;
            r.status    = st;
            r.last      = 1'b0;
            awaited.push_back(r);
        endfunction

        function void take_byte(logic cmd, logic [7:0] b);
            t_result tail;
            if (pos == 0) begin
                dir = cmd;
                absorb(b);
                add(b, 1'b0, ST_OK);
                pos = 7'd1;
            end else if (pos == 1) begin
                if (b > SIZE_LIMIT) begin
                    add(b, 1'b1, ST_SIZE_ERR);
                    restart();
                end else begin
                    frame_len = b[6:0];
                    absorb(b);
                    add(b, 1'b0, ST_OK);
                    pos = 7'd2;
                end
            end else if (pos < HEADER_LEN + frame_len) begin
                absorb(b);
                add(b, 1'b0, ST_OK);
                pos = pos + 7'd1;
                if (pos == HEADER_LEN + frame_len && dir == CMD_TX) begin
                    if (frame_len <= CRC8_MAX_SIZE) begin
                        add(crc8, 1'b1, ST_OK);
                    end else begin
                        add(crc16[7:0], 1'b0, ST_OK);
                        add(crc16[15:8], 1'b1, ST_OK);
                    end
                    restart();
                end
            end else if (frame_len <= CRC8_MAX_SIZE) begin
                add(b, 1'b1, (crc8 != b) ? ST_CRC_ERR : ST_OK);
                restart();
            end else if (pos == HEADER_LEN + frame_len) begin
                check_low = b;
                add(b, 1'b0, ST_OK);
                pos = pos + 7'd1;
            end else begin
                add(b, 1'b1, (crc16 != {b, check_low}) ? ST_CRC_ERR : ST_OK);
                restart();
            end
            tail = awaited.pop_back();
            tail.last = 1'b1;
            awaited.push_back(tail);
        endfunction

        function void check_output(t_result got);
            t_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                $error("unexpected result: out_byte %0h frame_end %0d status %0d last %0d",
                       got.out_byte, got.frame_end, got.status, got.last);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
            if (want.frame_end) begin
                case (want.status)
                    ST_OK:       frames_ok++;
                    ST_CRC_ERR:  frames_crc_bad++;
                    default:     frames_too_long++;
                endcase
            end
        endfunction
    endclass

    frame_tracker tracker = new();

    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = ~clk;
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(logic cmd, logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid     = 1'b1;
        in_ch.command   = cmd;
        in_ch.data_byte = b;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        tracker.take_byte(cmd, b);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.awaited.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_byte(int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receive frames carry a correct check value unless bad_check flips one bit of it.
    task automatic send_frame(logic dir, int len, bit bad_check, bit mix_cmd, int fill);
        logic [7:0]  seq[$];
        logic [7:0]  c8;
        logic [15:0] c16;
        int          first_check;
        int          k;
        seq.push_back(pick_byte(fill));
        seq.push_back(8'(len));
        if (len <= SIZE_LIMIT) begin
            seq.push_back(pick_byte(fill));
            repeat (len) seq.push_back(pick_byte(fill));
            if (dir == CMD_RX) begin
                c8  = CRC8_INIT;
                c16 = CRC16_INIT;
                foreach (seq[i]) begin
                    c8  = next_crc8(c8, seq[i]);
                    c16 = next_crc16(c16, seq[i]);
                end
                first_check = seq.size();
                if (len <= CRC8_MAX_SIZE) begin
                    seq.push_back(c8);
                end else begin
                    seq.push_back(c16[7:0]);
                    seq.push_back(c16[15:8]);
                end
                if (bad_check) begin
                    k = $urandom_range(first_check, seq.size() - 1);
                    seq[k] = seq[k] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
        end
        foreach (seq[i]) begin
            send_byte((i == 0 || !mix_cmd) ? dir : 1'($urandom_range(0, 1)), seq[i]);
        end
    endtask

    initial begin
        int      stall;
        t_result got;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            repeat (stall) begin
                @(negedge clk);
                out_ch.ready = 1'b0;
            end
            @(negedge clk);
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid) begin
                @(posedge clk);
            end
            got.out_byte  = out_ch.out_byte;
            got.frame_end = out_ch.frame_end;
            got.status    = out_ch.status;
            got.last      = out_ch.last;
            tracker.check_output(got);
        end
    end

    initial begin
        int  kind;
        int  len;
        int  k;
        logic dir;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_TX;
        in_ch.data_byte = 8'h00;
        rst_n           = 1'b0;
        quiet           = 1'b0;
        bytes_sent      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty frames, a bad CRC-8, both kinds of oversize, and command changes mid-frame.
        send_frame(CMD_TX, 0, 1'b0, 1'b0, FILL_ONES);
        send_frame(CMD_RX, 0, 1'b0, 1'b0, FILL_ZERO);
        send_frame(CMD_RX, 1, 1'b1, 1'b1, FILL_ONES);
        send_frame(CMD_TX, SIZE_LIMIT + 1, 1'b0, 1'b0, FILL_ZERO);
        send_frame(CMD_RX, 255, 1'b0, 1'b0, FILL_ONES);
        send_frame(CMD_TX, 2, 1'b0, 1'b1, FILL_ZERO);
        hold_until_drained();

        while (bytes_sent < 500) begin
            if ($urandom_range(0, 7) == 0) begin
                quiet = ~quiet;
            end
            if ($urandom_range(0, 24) == 0) begin
                hold_until_drained();
            end
            kind = $urandom_range(0, 99);
            dir  = 1'($urandom_range(0, 1));
            if (kind < 7) begin
                send_frame(dir, $urandom_range(SIZE_LIMIT + 1, 255), 1'b0, 1'b0, FILL_RANDOM);
            end else if (kind < 14) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                while (tracker.pos != 0) begin
                    send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end else begin
                k = $urandom_range(0, 19);
                if (k < 13) begin
                    len = $urandom_range(0, CRC8_MAX_SIZE);
                end else if (k < 18) begin
                    len = $urandom_range(CRC8_MAX_SIZE + 1, CRC8_MAX_SIZE + 9);
                end else begin
                    len = SIZE_LIMIT - $urandom_range(0, 2);
                end
                send_frame(dir, len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                           FILL_RANDOM);
            end
        end

        hold_until_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes and checked %0d results.", bytes_sent, tracker.results_seen);
        $display("Frames closed: %0d ok, %0d with check mismatch, %0d with size too large.",
                 tracker.frames_ok, tracker.frames_crc_bad, tracker.frames_too_long);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
